### sv/quaternion_to_dcm_macros.svh
// Assertion helpers for the RTL in quaternion_to_dcm.sv.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef QUATERNION_TO_DCM_MACROS_SVH
`define QUATERNION_TO_DCM_MACROS_SVH

// Same-cycle implication
`define Q2D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define Q2D_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/q2d_pkg.sv
`timescale 1ns / 1ps

package q2d_pkg;

	// Default sizes: Q2.14 in, Q2.14 out
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	localparam int NUM_COMP = 4;
	localparam int NUM_PROD = 9;
	localparam int NUM_ELEM = 9;

	// Quaternion components, scalar first
	typedef enum logic [1:0] {
		C_SCALAR,
		C_X,
		C_Y,
		C_Z
	} comp_t;

	// Distinct products needed by the matrix
	typedef enum logic [3:0] {
		P_BB,
		P_CC,
		P_DD,
		P_BC,
		P_BD,
		P_CD,
		P_AB,
		P_AC,
		P_AD
	} prod_t;

	typedef struct packed {
		comp_t opa;
		comp_t opb;
	} prod_def_t;

	// Element recipe: off-diagonal = 2(pa +/- pb), diagonal = 1.0 - 2(pa + pb)
	typedef struct packed {
		prod_t pa;
		prod_t pb;
		logic  neg_b;
		logic  diag;
	} elem_def_t;

	localparam prod_def_t PROD_DEF [NUM_PROD] = '{
		'{opa: C_X,      opb: C_X},
		'{opa: C_Y,      opb: C_Y},
		'{opa: C_Z,      opb: C_Z},
		'{opa: C_X,      opb: C_Y},
		'{opa: C_X,      opb: C_Z},
		'{opa: C_Y,      opb: C_Z},
		'{opa: C_SCALAR, opb: C_X},
		'{opa: C_SCALAR, opb: C_Y},
		'{opa: C_SCALAR, opb: C_Z}
	};

	// Row-major order m11 .. m33
	localparam elem_def_t ELEM_DEF [NUM_ELEM] = '{
		'{pa: P_CC, pb: P_DD, neg_b: 1'b0, diag: 1'b1},
		'{pa: P_BC, pb: P_AD, neg_b: 1'b0, diag: 1'b0},
		'{pa: P_BD, pb: P_AC, neg_b: 1'b1, diag: 1'b0},
		'{pa: P_BC, pb: P_AD, neg_b: 1'b1, diag: 1'b0},
		'{pa: P_BB, pb: P_DD, neg_b: 1'b0, diag: 1'b1},
		'{pa: P_CD, pb: P_AB, neg_b: 1'b0, diag: 1'b0},
		'{pa: P_BD, pb: P_AC, neg_b: 1'b0, diag: 1'b0},
		'{pa: P_CD, pb: P_AB, neg_b: 1'b1, diag: 1'b0},
		'{pa: P_BB, pb: P_CC, neg_b: 1'b0, diag: 1'b1}
	};

endpackage

### sv/quaternion_to_dcm.sv
`timescale 1ns / 1ps
`include "quaternion_to_dcm_macros.svh"

// Attitude quaternion to direction cosine matrix (NED to body).
// Input channel (in_valid/in_ready): one request carries q_scalar, q_x, q_y, q_z,
// signed fixed point with FRAC_BITS fraction bits, scalar part first.
// Output channel (out_valid/out_ready): one result per request, the nine
// elements m11..m33 in the same format, rounded half up and saturated.
// Pipeline: s1 input register, s2 nine products, s3 signed sums with rounding
// offset, s4 shift, diagonal 1.0 add, saturation into the output register.
// Order: a request is registered in s1, s2, s3 and then s4, whose valid bit
// drives out_valid; the result is accepted while out_ready is high.
// Throughput: one request per cycle through the four-stage register pipeline while out_ready is high.
// Each stage carries its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up.
// When the receiver holds out_ready low the results stay on the outputs and
// the pipeline fills; in_ready drops once all four stages hold a request.
// Nothing is lost or repeated under stalls.
// Reset (arst_n low) empties the pipeline; no state survives between requests.
module quaternion_to_dcm #(
	parameter int DATA_WIDTH = q2d_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = q2d_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] q_scalar,
	input  logic signed [DATA_WIDTH-1:0] q_x,
	input  logic signed [DATA_WIDTH-1:0] q_y,
	input  logic signed [DATA_WIDTH-1:0] q_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] m11,
	output logic signed [DATA_WIDTH-1:0] m12,
	output logic signed [DATA_WIDTH-1:0] m13,
	output logic signed [DATA_WIDTH-1:0] m21,
	output logic signed [DATA_WIDTH-1:0] m22,
	output logic signed [DATA_WIDTH-1:0] m23,
	output logic signed [DATA_WIDTH-1:0] m31,
	output logic signed [DATA_WIDTH-1:0] m32,
	output logic signed [DATA_WIDTH-1:0] m33
);
	import q2d_pkg::*;

	localparam int PW      = 2 * DATA_WIDTH;
	localparam int SW      = PW + 2;
	localparam int SHIFT_K = FRAC_BITS - 1;

	localparam logic signed [SW-1:0] HALF_K  = SW'(1) <<< (FRAC_BITS - 2);
	localparam logic signed [SW-1:0] ONE_Q   = SW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] OUT_MAX = (SW'(1) <<< (DATA_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] OUT_MIN = -(SW'(1) <<< (DATA_WIDTH - 1));

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [DATA_WIDTH-1:0] q_s1    [NUM_COMP];
	logic signed [PW-1:0]         prod_s2 [NUM_PROD];
	logic signed [SW-1:0]         sum_s3  [NUM_ELEM];
	logic signed [DATA_WIDTH-1:0] elem_s4 [NUM_ELEM];

	logic signed [SW-1:0] sum_d [NUM_ELEM];
	logic signed [SW-1:0] sat_d [NUM_ELEM];

	// a stage may load when empty or when its request moves on
	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// s1: capture the quaternion
	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			q_s1[C_SCALAR] <= q_scalar;
			q_s1[C_X]      <= q_x;
			q_s1[C_Y]      <= q_y;
			q_s1[C_Z]      <= q_z;
		end
	end

	// s2: the nine full-precision products
	for (genvar p = 0; p < NUM_PROD; p++) begin : g_prod
		always_ff @(posedge clk) begin
			if (v_s1 && adv2) begin
				prod_s2[p] <= q_s1[PROD_DEF[p].opa] * q_s1[PROD_DEF[p].opb];
			end
		end
	end

	// s3: signed pair sums plus the rounding offset
	for (genvar e = 0; e < NUM_ELEM; e++) begin : g_sum
		logic signed [SW-1:0] pa, pb;
		assign pa = SW'(prod_s2[ELEM_DEF[e].pa]);
		assign pb = SW'(prod_s2[ELEM_DEF[e].pb]);

		always_comb begin
			if (ELEM_DEF[e].diag) begin
				sum_d[e] = HALF_K - (pa + pb);
			end else if (ELEM_DEF[e].neg_b) begin
				sum_d[e] = HALF_K + pa - pb;
			end else begin
				sum_d[e] = HALF_K + pa + pb;
			end
		end

		always_ff @(posedge clk) begin
			if (v_s2 && adv3) begin
				sum_s3[e] <= sum_d[e];
			end
		end
	end

	// s4: drop fraction bits (floor), add 1.0 on the diagonal, saturate
	for (genvar e = 0; e < NUM_ELEM; e++) begin : g_out
		logic signed [SW-1:0] rnd;

		always_comb begin
			rnd = sum_s3[e] >>> SHIFT_K;
			if (ELEM_DEF[e].diag) begin
				rnd = rnd + ONE_Q;
			end
			if (rnd > OUT_MAX) begin
				sat_d[e] = OUT_MAX;
			end else if (rnd < OUT_MIN) begin
				sat_d[e] = OUT_MIN;
			end else begin
				sat_d[e] = rnd;
			end
		end

		always_ff @(posedge clk) begin
			if (v_s3 && adv4) begin
				elem_s4[e] <= sat_d[e][DATA_WIDTH-1:0];
			end
		end
	end

	assign out_valid = v_s4;
	assign m11       = elem_s4[0];
	assign m12       = elem_s4[1];
	assign m13       = elem_s4[2];
	assign m21       = elem_s4[3];
	assign m22       = elem_s4[4];
	assign m23       = elem_s4[5];
	assign m31       = elem_s4[6];
	assign m32       = elem_s4[7];
	assign m33       = elem_s4[8];

	// checks
	`Q2D_ASSERT_IMP(a_no_block, out_ready, in_ready, "pipeline blocked with sink ready")
	`Q2D_ASSERT_NXT(a_s1_moves, v_s1 && adv2, v_s2, "request lost between s1 and s2")
	`Q2D_ASSERT_NXT(a_s3_holds, v_s3 && !adv4, v_s3 && $stable(sum_s3[0]),
		"stalled s3 request changed")
	`Q2D_ASSERT_IMP(a_diag_max, out_valid, SW'(m11) <= ONE_Q, "diagonal above 1.0")

endmodule
